// ----- hw/rtl/osc_pkg.sv -----
// Shared types, constants and coefficient tables for the soft-clip distortion block.
// No dependencies; every other file in hw/rtl refers to it by scoped names.
`default_nettype none

package osc_pkg;

   // Datapath widths
   localparam int MAG_W      = 44;            // multiplier magnitude operand
   localparam int COEF_W     = 32;            // multiplier serial operand (Q0.32)
   localparam int PROD_W     = MAG_W + COEF_W;
   localparam int ST_W       = 40;            // Q10.30 state
   localparam int SUM_W      = 46;            // signed working width
   localparam int KNEE_W     = 25;
   localparam int STEP_W     = 26;
   localparam int NUM_W      = 40;            // clipper numerator magnitude
   localparam int QUO_W      = 42;            // clipper quotient magnitude
   localparam int O_W        = QUO_W + 1;     // signed clipper result
   localparam int PEND_W     = 32;            // Q3.28 pending output
   localparam int CSR_DATA_W = 26;

   localparam int COEF_SHIFT = 32;
   localparam int COMP_SHIFT = 34;
   localparam int KNEE_SHIFT = 30;

   localparam logic [KNEE_W-1:0] KNEE_ONE   = 25'd16777216;
   localparam logic [KNEE_W-1:0] GAIN_MAX   = 25'd17891328;
   localparam logic [KNEE_W-1:0] GAIN_RESET = 25'd5957818;

   typedef logic [COEF_W-1:0] coef_type;

   // All-pass coefficients 0.6, 1/3, 1/7 and raised-cosine blend weights, Q0.32
   localparam coef_type AP_COEF [3] = '{32'd2576980378, 32'd1431655765, 32'd613566757};
   localparam coef_type W_NEXT  [3] = '{32'd3665983898, 32'd2147483648, 32'd628983398};
   localparam coef_type W_PREV  [3] = '{32'd628983398,  32'd2147483648, 32'd3665983898};
   localparam coef_type COMP_Q32    = 32'd11811160;   // 0.011 / 4

   typedef enum logic [1:0] {
      CSR_DIST_START,
      CSR_DIST_STEP,
      CSR_DRIVE_START,
      CSR_DRIVE_STEP
   } csr_idx_type;

   typedef enum logic [1:0] {
      SH_DRIVE,
      SH_COEF,
      SH_COMP
   } shift_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DRIVE,
      ST_CLIP0,
      ST_AP,
      ST_AP_CLIP,
      ST_W_NEXT,
      ST_W_PREV,
      ST_SCALE,
      ST_COMP_PREV,
      ST_COMP_NEXT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic                 start;
      shift_type            shift;
      logic [MAG_W-1:0]     mag;
      coef_type             coef;
   } mul_req_type;

   typedef struct packed {
      logic                 start;
      logic [NUM_W-1:0]     mag;
      logic [KNEE_W-1:0]    knee;
   } div_req_type;

endpackage

`default_nettype wire

// ----- hw/rtl/osc_channels.sv -----
// Valid/ready channel interfaces: sample request, sample response and register write.
// Depends on osc_pkg for the register index type.
`default_nettype none

interface osc_req_if #(parameter int SAMPLE_BITS = 24);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_in;
   logic                          end_of_block;
   modport source (output valid, sample_in, end_of_block, input ready);
   modport sink   (input valid, sample_in, end_of_block, output ready);
endinterface

interface osc_rsp_if #(parameter int SAMPLE_BITS = 24);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_out;
   logic                          last;
   modport source (output valid, sample_out, last, input ready);
   modport sink   (input valid, sample_out, last, output ready);
endinterface

interface osc_csr_if;
   logic                                valid;
   logic                                ready;
   osc_pkg::csr_idx_type                index;
   logic [osc_pkg::CSR_DATA_W-1:0]      data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/osc_mul.sv -----
// Bit-serial shift-add multiplier, one coefficient bit per cycle, with rounded shift.
// Depends on osc_pkg for widths, shift codes and the request struct.
`default_nettype none

module osc_mul #(
   parameter int DRIVE_SHIFT = 9
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire osc_pkg::mul_req_type        req,
   output logic                             done,
   output logic [osc_pkg::MAG_W-1:0]        result
);

   localparam int CNT_W = $clog2(osc_pkg::COEF_W + 1);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [osc_pkg::MAG_W-1:0]     mag_ff, mag_in;
   osc_pkg::coef_type             coef_ff, coef_in;
   osc_pkg::shift_type            shift_ff, shift_in;
   logic [osc_pkg::PROD_W-1:0]    acc_ff, acc_in;
   logic [osc_pkg::MAG_W-1:0]     res_ff, res_in;
   logic [osc_pkg::MAG_W:0]       part;
   logic [osc_pkg::MAG_W-1:0]     rounded;

   // Partial sum for the current coefficient bit (LSB first)
   assign part = {1'b0, acc_ff[osc_pkg::PROD_W-1:osc_pkg::COEF_W]}
               + (coef_ff[0] ? {1'b0, mag_ff} : '0);

   // Round to nearest on the magnitude: add the bit just below the cut
   always_comb begin
      case (shift_ff)
         osc_pkg::SH_DRIVE: rounded = osc_pkg::MAG_W'(acc_ff >> DRIVE_SHIFT)
                                    + osc_pkg::MAG_W'(acc_ff[DRIVE_SHIFT-1]);
         osc_pkg::SH_COEF:  rounded = osc_pkg::MAG_W'(acc_ff >> osc_pkg::COEF_SHIFT)
                                    + osc_pkg::MAG_W'(acc_ff[osc_pkg::COEF_SHIFT-1]);
         osc_pkg::SH_COMP:  rounded = osc_pkg::MAG_W'(acc_ff >> osc_pkg::COMP_SHIFT)
                                    + osc_pkg::MAG_W'(acc_ff[osc_pkg::COMP_SHIFT-1]);
         default:           rounded = '0;
      endcase
   end

   // Sequencing: load, 32 shift-add steps, one rounding step
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      mag_in   = mag_ff;
      coef_in  = coef_ff;
      shift_in = shift_ff;
      acc_in   = acc_ff;
      res_in   = res_ff;
      if (req.start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         mag_in   = req.mag;
         coef_in  = req.coef;
         shift_in = req.shift;
         acc_in   = '0;
      end else if (busy_ff) begin
         if (cnt_ff == CNT_W'(osc_pkg::COEF_W)) begin
            res_in  = rounded;
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            acc_in  = {part, acc_ff[osc_pkg::COEF_W-1:1]};
            coef_in = coef_ff >> 1;
            cnt_in  = cnt_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mag_ff   <= mag_in;
      coef_ff  <= coef_in;
      shift_ff <= shift_in;
      acc_ff   <= acc_in;
      res_ff   <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/osc_div.sv -----
// Soft-clipper divider: |x| / ((1-d)|x| + d) in Q10.30, restoring, one quotient bit a cycle.
// Depends on osc_pkg for widths, the knee constant and the request struct.
`default_nettype none

module osc_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire osc_pkg::div_req_type        req,
   output logic                             done,
   output logic [osc_pkg::QUO_W-1:0]        result
);

   localparam int DEN_W  = osc_pkg::KNEE_W + osc_pkg::NUM_W;
   localparam int REM_W  = DEN_W + 1;
   localparam int CNT_W  = $clog2(osc_pkg::QUO_W);
   // Quotient bits above QUO_W are always zero, so the first 52 dividend bits load at once
   localparam int PRE_SH = 54 - osc_pkg::QUO_W;

   logic                          busy_ff, busy_in;
   logic                          prep_ff, prep_in;
   logic                          done_ff, done_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [osc_pkg::NUM_W-1:0]     num_ff, num_in;
   logic [osc_pkg::KNEE_W-1:0]    knee_ff, knee_in;
   logic [DEN_W-1:0]              den_ff, den_in;
   logic [REM_W-1:0]              rem_ff, rem_in;
   logic [osc_pkg::QUO_W-1:0]     quo_ff, quo_in;
   logic [DEN_W-1:0]              den_prod;
   logic [REM_W-1:0]              rem_sh;
   logic                          take;

   // Denominator (1-d)*n + d*2^30, all in Q54
   assign den_prod = DEN_W'(osc_pkg::KNEE_ONE - knee_ff) * DEN_W'(num_ff);
   assign rem_sh   = {rem_ff[REM_W-2:0], 1'b0};
   // Zero denominator only for zero input at zero knee: answer stays 0
   assign take     = (den_ff != '0) && (rem_sh >= REM_W'(den_ff));

   always_comb begin
      busy_in = busy_ff;
      prep_in = 1'b0;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      knee_in = knee_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (req.start) begin
         busy_in = 1'b1;
         prep_in = 1'b1;
         num_in  = req.mag;
         knee_in = req.knee;
      end else if (prep_ff) begin
         den_in = den_prod + (DEN_W'(knee_ff) << osc_pkg::KNEE_SHIFT);
         rem_in = REM_W'(num_ff) << PRE_SH;
         quo_in = '0;
         cnt_in = '0;
      end else if (busy_ff) begin
         rem_in = take ? rem_sh - REM_W'(den_ff) : rem_sh;
         quo_in = {quo_ff[osc_pkg::QUO_W-2:0], take};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(osc_pkg::QUO_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         prep_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         prep_ff <= prep_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff  <= num_in;
      knee_ff <= knee_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
   end

   assign done   = done_ff;
   assign result = quo_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/oversampled_soft_clip_distortion.sv -----
// Top level: 4x oversampled soft-clip distortion with drive/knee ramps and sequencer.
// Depends on osc_pkg, osc_channels (interfaces), osc_mul and osc_div.
//
//   channel  | dir | payload                       | item
//   req_ch   | in  | sample_in, end_of_block       | one input sample
//   rsp_ch   | out | sample_out, last              | output for the previous sample
//   csr_ch   | in  | index, data                   | one register write
//
// An item makes twelve passes through the bit-serial multiplier (32 steps plus load and
// rounding each) and four through the restoring divider (42 steps plus load and denominator
// set-up each), besides the scale, output and idle states. A new item is accepted only in
// the idle state, so the block finishes one item before it takes the next.
// Synchronous reset loads knee 1.0, drive 5957818 and clears all filter state.
// A finished item waits in the output register; the next item is taken meanwhile.
// Register writes are always accepted and are meant for idle periods.
`default_nettype none

module oversampled_soft_clip_distortion #(
   parameter int SAMPLE_BITS = 24
) (
   input  wire logic   clock,
   input  wire logic   reset,
   osc_req_if.sink     req_ch,
   osc_rsp_if.source   rsp_ch,
   osc_csr_if.sink     csr_ch
);

   localparam int FRAC        = SAMPLE_BITS - 1;
   localparam int DRIVE_SHIFT = FRAC - 14;
   localparam int OUT_RSH     = (FRAC <= 28) ? 28 - FRAC : 0;
   localparam int OUT_LSH     = (FRAC > 28) ? FRAC - 28 : 0;
   localparam int CUR_W       = 36;
   localparam int Y_W         = CUR_W + 4;
   localparam int SUM_W       = osc_pkg::SUM_W;
   localparam int ST_W        = osc_pkg::ST_W;
   localparam int KNEE_W      = osc_pkg::KNEE_W;
   localparam int STEP_W      = osc_pkg::STEP_W;
   localparam int O_W         = osc_pkg::O_W;
   localparam int PEND_W      = osc_pkg::PEND_W;
   localparam logic [CUR_W:0] OUT_HALF =
      (OUT_RSH == 0) ? '0 : ({{CUR_W{1'b0}}, 1'b1} << ((OUT_RSH == 0) ? 0 : OUT_RSH - 1));
   localparam logic [Y_W-1:0] OUT_LIM = {{(Y_W-1){1'b0}}, 1'b1} << FRAC;

   // Saturate a working value to the Q10.30 state range
   function automatic logic signed [ST_W-1:0] sat_state(input logic signed [SUM_W:0] v);
      logic signed [SUM_W:0] hi;
      logic signed [SUM_W:0] lo;
      hi = (SUM_W+1)'({1'b0, {(ST_W-1){1'b1}}});
      lo = -hi - (SUM_W+1)'(1);
      if (v > hi)      return ST_W'(hi);
      else if (v < lo) return ST_W'(lo);
      else             return ST_W'(v);
   endfunction

   function automatic logic signed [PEND_W-1:0] sat_pend(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = SUM_W'({1'b0, {(PEND_W-1){1'b1}}});
      lo = -hi - SUM_W'(1);
      if (v > hi)      return PEND_W'(hi);
      else if (v < lo) return PEND_W'(lo);
      else             return PEND_W'(v);
   endfunction

   function automatic logic [osc_pkg::MAG_W-1:0] mag_of(input logic signed [SUM_W-1:0] v);
      return v[SUM_W-1] ? osc_pkg::MAG_W'(-v) : osc_pkg::MAG_W'(v);
   endfunction

   // Linear ramp step, clamped to [0, hi]
   function automatic logic [KNEE_W-1:0] ramp(input logic [KNEE_W-1:0] v,
                                              input logic signed [STEP_W-1:0] s,
                                              input logic [KNEE_W-1:0] hi);
      logic signed [STEP_W:0] r;
      r = $signed({2'b00, v}) + (STEP_W+1)'(s);
      if (r < 0)                           return '0;
      else if (r > $signed({2'b00, hi}))   return hi;
      else                                 return KNEE_W'(r);
   endfunction

   function automatic logic [KNEE_W-1:0] clamp_load(input logic [KNEE_W-1:0] v,
                                                    input logic [KNEE_W-1:0] hi);
      return (v > hi) ? hi : v;
   endfunction

   osc_pkg::state_type            state_ff, state_in;
   logic [1:0]                    idx_ff, idx_in;
   logic                          neg_ff, neg_in;
   logic                          eob_ff, eob_in;
   logic signed [ST_W-1:0]        driven_ff, driven_in;
   logic signed [ST_W-1:0]        driven_prev_ff, driven_prev_in;
   logic signed [ST_W-1:0]        apm_ff [3];
   logic signed [ST_W-1:0]        apm_in [3];
   logic signed [O_W-1:0]         o_ff [3];
   logic signed [O_W-1:0]         o_in [3];
   logic signed [SUM_W-1:0]       next_sum_ff, next_sum_in;
   logic signed [SUM_W-1:0]       prev_sum_ff, prev_sum_in;
   logic signed [PEND_W-1:0]      pending_ff, pending_in;
   logic signed [CUR_W-1:0]       cur_ff, cur_in;
   logic [KNEE_W-1:0]             knee_ff, knee_in;
   logic [KNEE_W-1:0]             gain_ff, gain_in;
   logic signed [STEP_W-1:0]      dstep_ff, dstep_in;
   logic signed [STEP_W-1:0]      gstep_ff, gstep_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] sample_out_ff, sample_out_in;
   logic                          last_ff, last_in;

   osc_pkg::mul_req_type          mreq;
   osc_pkg::div_req_type          dreq;
   logic                          mul_done;
   logic [osc_pkg::MAG_W-1:0]     mul_res;
   logic                          div_done;
   logic [osc_pkg::QUO_W-1:0]     div_res;

   logic signed [SUM_W-1:0]       mres;
   logic signed [SUM_W-1:0]       dres;
   logic signed [SAMPLE_BITS:0]   x_wide;
   logic [SAMPLE_BITS:0]          x_mag;
   logic [1:0]                    idx_nx;

   logic                          cur_neg;
   logic [CUR_W-1:0]              cur_mag;
   logic [CUR_W:0]                cur_rnd;
   logic [Y_W-1:0]                y_mag;
   logic [Y_W-1:0]                y_sat;
   logic [Y_W-1:0]                y_val;

   osc_mul #(.DRIVE_SHIFT(DRIVE_SHIFT)) u_mul (
      .clock  (clock),
      .reset  (reset),
      .req    (mreq),
      .done   (mul_done),
      .result (mul_res)
   );

   osc_div u_div (
      .clock  (clock),
      .reset  (reset),
      .req    (dreq),
      .done   (div_done),
      .result (div_res)
   );

   // Signed unit results
   assign mres   = neg_ff ? -SUM_W'(mul_res) : SUM_W'(mul_res);
   assign dres   = neg_ff ? -SUM_W'(div_res) : SUM_W'(div_res);
   assign x_wide = (SAMPLE_BITS+1)'(req_ch.sample_in);
   assign x_mag  = x_wide[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-x_wide) : (SAMPLE_BITS+1)'(x_wide);
   assign idx_nx = idx_ff + 2'd1;

   // Q3.28 to sample format: round on magnitude, then saturate
   always_comb begin
      cur_neg = cur_ff[CUR_W-1];
      cur_mag = cur_neg ? CUR_W'(-cur_ff) : CUR_W'(cur_ff);
      cur_rnd = {1'b0, cur_mag} + OUT_HALF;
      y_mag   = Y_W'(cur_rnd >> OUT_RSH) << OUT_LSH;
      if (cur_neg) begin
         y_sat = (y_mag > OUT_LIM) ? OUT_LIM : y_mag;
         y_val = -y_sat;
      end else begin
         y_sat = (y_mag >= OUT_LIM) ? OUT_LIM - Y_W'(1) : y_mag;
         y_val = y_sat;
      end
   end

   // Sequencer: next state, unit requests and datapath updates
   always_comb begin
      logic signed [ST_W-1:0]  d_sat;
      logic signed [SUM_W-1:0] diff;
      state_in       = state_ff;
      idx_in         = idx_ff;
      neg_in         = neg_ff;
      eob_in         = eob_ff;
      driven_in      = driven_ff;
      driven_prev_in = driven_prev_ff;
      apm_in         = apm_ff;
      o_in           = o_ff;
      next_sum_in    = next_sum_ff;
      prev_sum_in    = prev_sum_ff;
      pending_in     = pending_ff;
      cur_in         = cur_ff;
      knee_in        = knee_ff;
      gain_in        = gain_ff;
      dstep_in       = dstep_ff;
      gstep_in       = gstep_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      sample_out_in  = sample_out_ff;
      last_in        = last_ff;
      mreq           = '0;
      dreq           = '0;
      d_sat          = '0;
      diff           = '0;

      case (state_ff)
         osc_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               mreq.start = 1'b1;
               mreq.shift = osc_pkg::SH_DRIVE;
               mreq.mag   = osc_pkg::MAG_W'(x_mag);
               mreq.coef  = osc_pkg::COEF_W'(gain_ff);
               neg_in     = req_ch.sample_in[SAMPLE_BITS-1];
               eob_in     = req_ch.end_of_block;
               state_in   = osc_pkg::ST_DRIVE;
            end
         end
         osc_pkg::ST_DRIVE: begin
            if (mul_done) begin
               d_sat      = sat_state((SUM_W+1)'(mres));
               driven_in  = d_sat;
               dreq.start = 1'b1;
               dreq.mag   = osc_pkg::NUM_W'(mag_of(SUM_W'(d_sat)));
               dreq.knee  = knee_ff;
               neg_in     = d_sat[ST_W-1];
               state_in   = osc_pkg::ST_CLIP0;
            end
         end
         osc_pkg::ST_CLIP0: begin
            if (div_done) begin
               next_sum_in = dres;
               prev_sum_in = '0;
               idx_in      = '0;
               diff        = SUM_W'(driven_ff) - SUM_W'(apm_ff[0]);
               mreq.start  = 1'b1;
               mreq.shift  = osc_pkg::SH_COEF;
               mreq.mag    = mag_of(diff);
               mreq.coef   = osc_pkg::AP_COEF[0];
               neg_in      = diff[SUM_W-1];
               state_in    = osc_pkg::ST_AP;
            end
         end
         // All-pass section: y = prev + g*(x - y_old), then clip it
         osc_pkg::ST_AP: begin
            if (mul_done) begin
               d_sat          = sat_state((SUM_W+1)'(driven_prev_ff) + (SUM_W+1)'(mres));
               apm_in[idx_ff] = d_sat;
               dreq.start     = 1'b1;
               dreq.mag       = osc_pkg::NUM_W'(mag_of(SUM_W'(d_sat)));
               dreq.knee      = knee_ff;
               neg_in         = d_sat[ST_W-1];
               state_in       = osc_pkg::ST_AP_CLIP;
            end
         end
         osc_pkg::ST_AP_CLIP: begin
            if (div_done) begin
               o_in[idx_ff] = O_W'(dres);
               mreq.start   = 1'b1;
               mreq.shift   = osc_pkg::SH_COEF;
               if (idx_ff == 2'd2) begin
                  idx_in    = '0;
                  mreq.mag  = mag_of(SUM_W'(o_ff[0]));
                  mreq.coef = osc_pkg::W_NEXT[0];
                  neg_in    = o_ff[0][O_W-1];
                  state_in  = osc_pkg::ST_W_NEXT;
               end else begin
                  idx_in    = idx_nx;
                  diff      = SUM_W'(driven_ff) - SUM_W'(apm_ff[idx_nx]);
                  mreq.mag  = mag_of(diff);
                  mreq.coef = osc_pkg::AP_COEF[idx_nx];
                  neg_in    = diff[SUM_W-1];
                  state_in  = osc_pkg::ST_AP;
               end
            end
         end
         // Blend weights for this and the next output
         osc_pkg::ST_W_NEXT: begin
            if (mul_done) begin
               next_sum_in = next_sum_ff + mres;
               mreq.start  = 1'b1;
               mreq.shift  = osc_pkg::SH_COEF;
               mreq.mag    = mag_of(SUM_W'(o_ff[idx_ff]));
               mreq.coef   = osc_pkg::W_PREV[idx_ff];
               neg_in      = o_ff[idx_ff][O_W-1];
               state_in    = osc_pkg::ST_W_PREV;
            end
         end
         osc_pkg::ST_W_PREV: begin
            if (mul_done) begin
               prev_sum_in = prev_sum_ff + mres;
               if (idx_ff == 2'd2) begin
                  state_in = osc_pkg::ST_SCALE;
               end else begin
                  idx_in     = idx_nx;
                  mreq.start = 1'b1;
                  mreq.shift = osc_pkg::SH_COEF;
                  mreq.mag   = mag_of(SUM_W'(o_ff[idx_nx]));
                  mreq.coef  = osc_pkg::W_NEXT[idx_nx];
                  neg_in     = o_ff[idx_nx][O_W-1];
                  state_in   = osc_pkg::ST_W_NEXT;
               end
            end
         end
         osc_pkg::ST_SCALE: begin
            mreq.start = 1'b1;
            mreq.shift = osc_pkg::SH_COMP;
            mreq.mag   = mag_of(prev_sum_ff);
            mreq.coef  = osc_pkg::COMP_Q32;
            neg_in     = prev_sum_ff[SUM_W-1];
            state_in   = osc_pkg::ST_COMP_PREV;
         end
         osc_pkg::ST_COMP_PREV: begin
            if (mul_done) begin
               cur_in     = CUR_W'(pending_ff) + CUR_W'(mres);
               mreq.start = 1'b1;
               mreq.shift = osc_pkg::SH_COMP;
               mreq.mag   = mag_of(next_sum_ff);
               mreq.coef  = osc_pkg::COMP_Q32;
               neg_in     = next_sum_ff[SUM_W-1];
               state_in   = osc_pkg::ST_COMP_NEXT;
            end
         end
         osc_pkg::ST_COMP_NEXT: begin
            if (mul_done) begin
               pending_in = sat_pend(mres);
               state_in   = osc_pkg::ST_OUT;
            end
         end
         // Hand over the item once the output register is free; advance the ramps
         osc_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in   = 1'b1;
               sample_out_in  = SAMPLE_BITS'(y_val);
               last_in        = eob_ff;
               driven_prev_in = driven_ff;
               knee_in        = ramp(knee_ff, dstep_ff, osc_pkg::KNEE_ONE);
               gain_in        = ramp(gain_ff, gstep_ff, osc_pkg::GAIN_MAX);
               state_in       = osc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = osc_pkg::ST_IDLE;
         end
      endcase

      // Register writes
      if (csr_ch.valid) begin
         case (csr_ch.index)
            osc_pkg::CSR_DIST_START:
               knee_in = clamp_load(KNEE_W'(csr_ch.data), osc_pkg::KNEE_ONE);
            osc_pkg::CSR_DIST_STEP:
               dstep_in = STEP_W'(csr_ch.data);
            osc_pkg::CSR_DRIVE_START:
               gain_in = clamp_load(KNEE_W'(csr_ch.data), osc_pkg::GAIN_MAX);
            osc_pkg::CSR_DRIVE_STEP:
               gstep_in = STEP_W'(csr_ch.data);
            default: begin
               dstep_in = dstep_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= osc_pkg::ST_IDLE;
         idx_ff         <= '0;
         driven_prev_ff <= '0;
         apm_ff         <= '{default: '0};
         pending_ff     <= '0;
         knee_ff        <= osc_pkg::KNEE_ONE;
         gain_ff        <= osc_pkg::GAIN_RESET;
         dstep_ff       <= '0;
         gstep_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         idx_ff         <= idx_in;
         driven_prev_ff <= driven_prev_in;
         apm_ff         <= apm_in;
         pending_ff     <= pending_in;
         knee_ff        <= knee_in;
         gain_ff        <= gain_in;
         dstep_ff       <= dstep_in;
         gstep_ff       <= gstep_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      neg_ff        <= neg_in;
      eob_ff        <= eob_in;
      driven_ff     <= driven_in;
      o_ff          <= o_in;
      next_sum_ff   <= next_sum_in;
      prev_sum_ff   <= prev_sum_in;
      cur_ff        <= cur_in;
      sample_out_ff <= sample_out_in;
      last_ff       <= last_in;
   end

   assign req_ch.ready      = (state_ff == osc_pkg::ST_IDLE);
   assign csr_ch.ready      = 1'b1;
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.sample_out = sample_out_ff;
   assign rsp_ch.last       = last_ff;

endmodule

`default_nettype wire
